FILE: rtl/core/nfl_pkg.sv
// Package for the nearest-four light selector: sizes, command codes and the
// transaction structs passed between the sequencer, distance unit and sorter.
// No dependencies.
package nfl_pkg;

  localparam int MAX_LIGHTS    = 32;
  localparam int COORD_BITS    = 16;
  localparam int NEAREST_COUNT = 4;
  localparam int OUT_SLOTS     = 4;

  localparam int IDX_W  = $clog2(MAX_LIGHTS);
  localparam int CNT_W  = $clog2(MAX_LIGHTS) + 1;
  localparam int THR_W  = 6;
  localparam int POS_W  = 3 * COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  localparam logic [IDX_W-1:0] NONE_INDEX    = IDX_W'(31);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(3);

  localparam logic [1:0] CMD_RESET   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_PUBLISH = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
  } read_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } cand_t;

endpackage

FILE: rtl/core/nfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/nfl_dist.sv
// Pipelined squared-distance unit: absolute differences, squares, sum.
// Depends on nfl_pkg.
module nfl_dist import nfl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  read_t                 rd,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  input  logic [COORD_BITS-1:0] q_z,
  output cand_t                 cand,
  output logic                  busy
);

  logic [COORD_BITS-1:0] q [3];
  logic [COORD_BITS-1:0] abs_next [3];
  logic [COORD_BITS-1:0] s1_abs [3];
  logic [SQ_W-1:0]       s2_sq [3];
  logic                  s1_valid, s2_valid;
  logic [IDX_W-1:0]      s1_idx, s2_idx;

  assign q[0] = q_x;
  assign q[1] = q_y;
  assign q[2] = q_z;

  always_comb begin
    logic [COORD_BITS-1:0] p;
    logic [COORD_BITS:0]   d;
    for (int i = 0; i < 3; i++) begin
      p = rd.pos[(3-i)*COORD_BITS-1 -: COORD_BITS];
      d = {p[COORD_BITS-1], p} - {q[i][COORD_BITS-1], q[i]};
      if (d[COORD_BITS]) begin
        d = -d;
      end
      abs_next[i] = d[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      cand.valid <= 1'b0;
    end else begin
      s1_valid   <= rd.valid;
      s2_valid   <= s1_valid;
      cand.valid <= s2_valid;
    end
    s1_idx   <= rd.idx;
    s2_idx   <= s1_idx;
    cand.idx <= s2_idx;
    for (int i = 0; i < 3; i++) begin
      s1_abs[i] <= abs_next[i];
      s2_sq[i]  <= SQ_W'(s1_abs[i]) * SQ_W'(s1_abs[i]);
    end
    cand.sq_dist <= DIST_W'(s2_sq[0]) + DIST_W'(s2_sq[1]) + DIST_W'(s2_sq[2]);
  end

  assign busy = s1_valid || s2_valid || cand.valid;

endmodule

FILE: rtl/core/nfl_top4.sv
// Sorted list of the nearest candidates, one insertion per cycle.
// Depends on nfl_pkg.
module nfl_top4 import nfl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  cand_t            cand,
  output logic [IDX_W-1:0] best [OUT_SLOTS]
);

  logic              lst_valid [OUT_SLOTS];
  logic [IDX_W-1:0]  lst_idx   [OUT_SLOTS];
  logic [DIST_W-1:0] lst_dist  [OUT_SLOTS];
  logic              lt        [OUT_SLOTS];

  always_comb begin
    for (int k = 0; k < OUT_SLOTS; k++) begin
      lt[k]   = (k < NEAREST_COUNT) && (!lst_valid[k] || (cand.sq_dist < lst_dist[k]));
      best[k] = lst_valid[k] ? lst_idx[k] : NONE_INDEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int k = 0; k < OUT_SLOTS; k++) begin
        lst_valid[k] <= 1'b0;
      end
    end else if (cand.valid) begin
      for (int k = 0; k < OUT_SLOTS; k++) begin
        if (lt[k]) begin
          if (k == 0 || !lt[(k == 0) ? 0 : k-1]) begin
            lst_valid[k] <= 1'b1;
            lst_idx[k]   <= cand.idx;
            lst_dist[k]  <= cand.sq_dist;
          end else begin
            lst_valid[k] <= lst_valid[(k == 0) ? 0 : k-1];
            lst_idx[k]   <= lst_idx[(k == 0) ? 0 : k-1];
            lst_dist[k]  <= lst_dist[(k == 0) ? 0 : k-1];
          end
        end
      end
    end
  end

endmodule

FILE: rtl/core/nearest_four_light_selector_top.sv
// Nearest-four light selector: light table, command sequencer and APB register.
// Depends on nfl_pkg, nfl_ram, nfl_dist and nfl_top4.
// A reset, add, publish or query with selection off is answered from idle; a query with
// selection on scans the stored lights, one read per cycle, and answers once drained.
// Throughput: one transaction at a time; the next is accepted as the result is taken.
// Reset: synchronous; clears light count, selection and threshold (to 3).
module nearest_four_light_selector_top import nfl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic        is_directional,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  nearest_0,
  output logic [4:0]  nearest_1,
  output logic [4:0]  nearest_2,
  output logic [4:0]  nearest_3,
  output logic        table_full
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic REG_SPLIT_THRESHOLD = 1'b0;

  logic [1:0]            state;
  logic [THR_W-1:0]      split_threshold;
  logic [CNT_W-1:0]      light_count;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  sel_en;
  logic [IDX_W-1:0]      scan_idx;
  logic [COORD_BITS-1:0] q_x, q_y, q_z;
  logic [IDX_W-1:0]      res [OUT_SLOTS];
  logic                  res_full;
  logic                  add_full;
  logic                  out_set;
  logic                  in_acc, out_free, cfg_wr;
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [POS_W-1:0]      rd_data;
  logic                  rd_valid;
  logic [IDX_W-1:0]      rd_idx;
  read_t                 rd;
  cand_t                 cand;
  logic                  dist_busy;
  logic [IDX_W-1:0]      best [OUT_SLOTS];
  logic                  top4_clear;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_SPLIT_THRESHOLD) ? 32'(split_threshold) : 32'd0;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign cnt_inc  = light_count + CNT_W'(1);
  assign add_full = (command == CMD_ADD) && !is_directional &&
                    (light_count >= CNT_W'(MAX_LIGHTS - 1));
  assign wr_en    = in_acc && (command == CMD_ADD) &&
                    (is_directional || (light_count < CNT_W'(MAX_LIGHTS - 1)));
  assign wr_addr  = is_directional ? IDX_W'(0) : cnt_inc[IDX_W-1:0];
  assign rd_en    = (state == ST_SCAN);
  assign top4_clear = in_acc && (command == CMD_QUERY);
  assign out_set  = ((state == ST_IDLE) && in_acc && !((command == CMD_QUERY) && sel_en)) ||
                    ((state == ST_DONE) && out_free);

  nfl_ram #(.WIDTH(POS_W), .DEPTH(MAX_LIGHTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({pos_x[COORD_BITS-1:0], pos_y[COORD_BITS-1:0], pos_z[COORD_BITS-1:0]}),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  assign rd = '{valid: rd_valid, idx: rd_idx, pos: rd_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
    rd_idx <= scan_idx;
  end

  nfl_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .rd   (rd),
    .q_x  (q_x),
    .q_y  (q_y),
    .q_z  (q_z),
    .cand (cand),
    .busy (dist_busy)
  );

  nfl_top4 u_top4 (
    .clk   (clk),
    .rst   (rst),
    .clear (top4_clear),
    .cand  (cand),
    .best  (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      split_threshold <= THRESHOLD_RST;
    end else if (cfg_wr && (paddr[2] == REG_SPLIT_THRESHOLD)) begin
      split_threshold <= pwdata[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_set) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      light_count <= '0;
      sel_en      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (command != CMD_QUERY) begin
              for (int k = 0; k < OUT_SLOTS; k++) begin
                res[k] <= '0;
              end
              res_full <= add_full;
            end
            unique case (command)
              CMD_RESET: begin
                light_count <= '0;
                sel_en      <= 1'b0;
              end
              CMD_ADD: begin
                if (!is_directional && (light_count < CNT_W'(MAX_LIGHTS - 1))) begin
                  light_count <= cnt_inc;
                end
              end
              CMD_PUBLISH: begin
                if (light_count >= CNT_W'(split_threshold)) begin
                  sel_en <= 1'b1;
                end
              end
              CMD_QUERY: begin
                if (sel_en) begin
                  q_x      <= pos_x[COORD_BITS-1:0];
                  q_y      <= pos_y[COORD_BITS-1:0];
                  q_z      <= pos_z[COORD_BITS-1:0];
                  scan_idx <= IDX_W'(1);
                  state    <= (light_count == '0) ? ST_DRAIN : ST_SCAN;
                end else begin
                  for (int k = 0; k < OUT_SLOTS; k++) begin
                    res[k] <= IDX_W'(k + 1);
                  end
                  res_full <= 1'b0;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (CNT_W'(scan_idx) == light_count) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!rd.valid && !dist_busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            for (int k = 0; k < OUT_SLOTS; k++) begin
              res[k] <= best[k];
            end
            res_full <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign nearest_0  = res[0];
  assign nearest_1  = res[1];
  assign nearest_2  = res[2];
  assign nearest_3  = res[3];
  assign table_full = res_full;

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    light_count <= CNT_W'(MAX_LIGHTS - 1))
    else $error("light count above capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((scan_idx != '0) && (CNT_W'(scan_idx) <= light_count)))
    else $error("scan index outside stored lights");

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (command == CMD_QUERY) && sel_en) |=> (state != ST_IDLE) && !out_valid)
    else $error("enabled query did not start a scan");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (!rd.valid && !dist_busy))
    else $error("result taken while distances still in flight");

endmodule

FILE: tb/tb_nearest_four_light_selector_top.sv
// Testbench for nearest_four_light_selector_top: directed and random command streams
// checked against an in-bench light table and nearest-four predictor.
// Depends on nfl_pkg and the RTL of the selector.
`timescale 1ns / 100ps

module tb_nearest_four_light_selector_top import nfl_pkg::*; ();

  localparam logic [2:0] ADDR_SPLIT_THRESHOLD = 3'd0;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]         command;
    logic               is_directional;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } light_cmd_t;

  typedef struct packed {
    logic [3:0][4:0] nearest;
    logic            table_full;
  } selection_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic is_directional = 1'b0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] nearest_0;
  logic [4:0] nearest_1;
  logic [4:0] nearest_2;
  logic [4:0] nearest_3;
  logic table_full;

  nearest_four_light_selector_top i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .is_directional(is_directional),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .nearest_0(nearest_0), .nearest_1(nearest_1), .nearest_2(nearest_2),
    .nearest_3(nearest_3), .table_full(table_full)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // light table mirror
  logic signed [15:0] light_x [MAX_LIGHTS];
  logic signed [15:0] light_y [MAX_LIGHTS];
  logic signed [15:0] light_z [MAX_LIGHTS];
  int unsigned        light_count = 0;
  bit                 selection_on = 1'b0;
  logic [THR_W-1:0]   split_threshold = THRESHOLD_RST;

  light_cmd_t pending_cmd_q[$];
  selection_t expected_selection_q[$];
  int errors = 0;
  int items_pushed = 0;

  int gap_max = 0;
  int stall_mode = 0;
  bit hold_phase = 1'b0;
  bit hold_done = 1'b0;

  function automatic selection_t predict_selection(input light_cmd_t c);
    selection_t r;
    bit taken [MAX_LIGHTS];
    longint dx, dy, dz, d, best_d;
    int best;
    bit found;
    r = '0;
    case (c.command)
      CMD_RESET: begin
        light_count = 0;
        selection_on = 1'b0;
      end
      CMD_ADD: begin
        if (c.is_directional) begin
          light_x[0] = c.pos_x;
          light_y[0] = c.pos_y;
          light_z[0] = c.pos_z;
        end else if (light_count >= MAX_LIGHTS - 1) begin
          r.table_full = 1'b1;
        end else begin
          light_x[light_count + 1] = c.pos_x;
          light_y[light_count + 1] = c.pos_y;
          light_z[light_count + 1] = c.pos_z;
          light_count++;
        end
      end
      CMD_PUBLISH: begin
        if (light_count >= split_threshold) selection_on = 1'b1;
      end
      default: begin
        if (!selection_on) begin
          for (int k = 0; k < OUT_SLOTS; k++) r.nearest[k] = 5'(k + 1);
        end else begin
          foreach (taken[j]) taken[j] = 1'b0;
          for (int k = 0; k < OUT_SLOTS; k++) begin
            found = 1'b0;
            best = NONE_INDEX;
            best_d = 0;
            if (k < NEAREST_COUNT) begin
              for (int j = 1; j <= int'(light_count); j++) begin
                if (!taken[j]) begin
                  dx = longint'(light_x[j]) - longint'(c.pos_x);
                  dy = longint'(light_y[j]) - longint'(c.pos_y);
                  dz = longint'(light_z[j]) - longint'(c.pos_z);
                  d = dx * dx + dy * dy + dz * dz;
                  if (!found || d < best_d) begin
                    found = 1'b1;
                    best_d = d;
                    best = j;
                  end
                end
              end
              if (found) taken[best] = 1'b1;
            end
            r.nearest[k] = found ? 5'(best) : NONE_INDEX;
          end
        end
      end
    endcase
    return r;
  endfunction

  // driver: bursts of transactions with random gaps
  light_cmd_t cur_cmd;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_selection_q.push_back(predict_selection(cur_cmd));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_cmd_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_cmd = pending_cmd_q.pop_front();
          command <= cur_cmd.command;
          is_directional <= cur_cmd.is_directional;
          pos_x <= cur_cmd.pos_x;
          pos_y <= cur_cmd.pos_y;
          pos_z <= cur_cmd.pos_z;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  logic [15:0] stall_pat = 16'b1110_0000_1100_1000;
  int hold_cycles = 0;

  always @(posedge clk) begin
    logic stall_next;
    stall_next = 1'b0;
    if (!rst) begin
      if (hold_phase && !hold_done) begin
        hold_cycles++;
        stall_next = 1'b1;
        if (hold_cycles >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        case (stall_mode)
          1: stall_next = ($urandom_range(0, 2) == 0);
          2: begin
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            stall_next = stall_pat[0];
          end
          default: stall_next = 1'b0;
        endcase
      end
    end
    out_stall <= stall_next;
  end

  // monitor
  always @(posedge clk) begin
    selection_t exp_sel;
    logic [3:0][4:0] got;
    if (!rst && out_valid && !out_stall) begin
      if (expected_selection_q.size() == 0) begin
        $error("unexpected result: nearest %0d %0d %0d %0d table_full %0d",
               nearest_0, nearest_1, nearest_2, nearest_3, table_full);
        errors++;
      end else begin
        exp_sel = expected_selection_q.pop_front();
        got = {nearest_3, nearest_2, nearest_1, nearest_0};
        for (int k = 0; k < OUT_SLOTS; k++) begin
          if (got[k] !== exp_sel.nearest[k]) begin
            $error("nearest_%0d: expected %0d, actual %0d", k, exp_sel.nearest[k], got[k]);
            errors++;
          end
        end
        if (table_full !== exp_sel.table_full) begin
          $error("table_full: expected %0d, actual %0d", exp_sel.table_full, table_full);
          errors++;
        end
      end
    end
  end

  task automatic push_cmd(input logic [1:0] cmd, input logic dir,
                          input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z);
    light_cmd_t c;
    c.command = cmd;
    c.is_directional = dir;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    pending_cmd_q.push_back(c);
    items_pushed++;
  endtask

  function automatic logic signed [15:0] pick_coord(input int spread);
    case (spread)
      1: return 16'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_light_cmd(input logic [1:0] cmd, input logic dir, input int spread);
    int s;
    s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : spread;
    push_cmd(cmd, dir, pick_coord(s), pick_coord(s), pick_coord(s));
  endtask

  task automatic push_noise_cmd();
    push_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
             pick_coord(0), pick_coord(0), pick_coord(0));
  endtask

  // reset table, fill it, publish, then query
  task automatic build_scene(input int n_lights, input int n_queries);
    int spread;
    spread = $urandom_range(0, 2);
    push_light_cmd(CMD_RESET, 1'($urandom_range(0, 1)), 0);
    if ($urandom_range(0, 2) == 0) push_light_cmd(CMD_QUERY, 1'($urandom_range(0, 1)), spread);
    for (int i = 0; i < n_lights; i++) begin
      push_light_cmd(CMD_ADD, ($urandom_range(0, 7) == 0), spread);
      if ($urandom_range(0, 5) == 0) push_light_cmd(CMD_PUBLISH, 1'($urandom_range(0, 1)), 0);
      if ($urandom_range(0, 4) == 0) push_light_cmd(CMD_QUERY, 1'b0, spread);
    end
    push_light_cmd(CMD_PUBLISH, 1'($urandom_range(0, 1)), 0);
    for (int i = 0; i < n_queries; i++) begin
      if ($urandom_range(0, 9) == 0) push_noise_cmd();
      else push_light_cmd(CMD_QUERY, 1'($urandom_range(0, 1)), spread);
    end
  endtask

  task automatic write_split_threshold(input logic [THR_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SPLIT_THRESHOLD;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    split_threshold = value;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmd_q.size() != 0 || in_valid || expected_selection_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase;
    logic [THR_W-1:0] thr;
    phase = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gap_max = 2;
    stall_mode = 1;
    push_cmd(CMD_QUERY, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_cmd(CMD_ADD, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_cmd(CMD_ADD, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    push_cmd(CMD_ADD, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_cmd(CMD_PUBLISH, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_cmd(CMD_QUERY, 1'b1, 16'sh7fff, 16'sh8000, 16'sh0001);
    push_cmd(CMD_ADD, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_cmd(CMD_ADD, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_cmd(CMD_PUBLISH, 1'b1, 16'shffff, 16'shffff, 16'shffff);
    push_cmd(CMD_QUERY, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_cmd(CMD_QUERY, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    push_cmd(CMD_ADD, 1'b0, 16'sh0001, 16'sh0001, 16'sh0001);
    push_cmd(CMD_QUERY, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_cmd(CMD_ADD, 1'b1, 16'shffff, 16'shffff, 16'shffff);
    push_cmd(CMD_QUERY, 1'b0, 16'shffff, 16'shffff, 16'shffff);
    push_cmd(CMD_RESET, 1'b1, 16'sh5555, 16'shaaaa, 16'sh7fff);
    push_cmd(CMD_QUERY, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_cmd(CMD_PUBLISH, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    wait_idle();

    // selection on an empty table
    write_split_threshold('0);
    push_cmd(CMD_PUBLISH, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_cmd(CMD_QUERY, 1'b0, 16'sh1234, 16'sh8000, 16'sh7fff);
    push_cmd(CMD_ADD, 1'b0, 16'sh0010, 16'shfff0, 16'sh0000);
    push_cmd(CMD_QUERY, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    wait_idle();

    while (items_pushed < 825) begin
      case (phase % 5)
        0: thr = 6'd32;
        1: thr = 6'd0;
        2: thr = 6'($urandom_range(0, 32));
        3: thr = 6'd31;
        default: thr = 6'($urandom_range(0, 8));
      endcase
      write_split_threshold(thr);
      case (phase % 4)
        0: gap_max = 0;
        1: gap_max = 3;
        2: gap_max = 10;
        default: gap_max = 1;
      endcase
      stall_mode = phase % 3;
      if (phase == 2) gap_max = 0;
      for (int s = 0; s < 2; s++) begin
        if ($urandom_range(0, 3) == 0 || phase == 3)
          build_scene($urandom_range(28, 34), $urandom_range(3, 10));
        else
          build_scene($urandom_range(0, 10), $urandom_range(3, 12));
      end
      if (phase == 2) hold_phase = 1'b1;
      wait_idle();
      phase++;
    end

    repeat (60) @(negedge clk);
    if (expected_selection_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_selection_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("tb: failure");
    $finish;
  end

endmodule
